>>> hdl/deq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, types and slot arithmetic for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH  = 1024;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = 11;
    localparam int DATA_W = 32;
    localparam int MODE_W = 3;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_PUSH_FRONT = 3'd0;
    localparam mode_t MODE_PUSH_BACK  = 3'd1;
    localparam mode_t MODE_POP_FRONT  = 3'd2;
    localparam mode_t MODE_POP_BACK   = 3'd3;

    localparam count_t COUNT_FULL = CNT_W'(DEPTH);
    localparam slot_t  SLOT_LAST  = SLOT_W'(DEPTH - 1);

    typedef struct packed {
        data_t  popped_value;
        logic   pop_valid;
        logic   push_dropped;
        count_t entry_count;
        logic   is_empty;
        data_t  front_value;
        data_t  back_value;
        logic   ends_valid;
    } result_t;

    typedef struct packed {
        logic  we;
        slot_t waddr;
        data_t wdata;
        slot_t raddr;
    } ram_cmd_t;

    function automatic slot_t slot_next(input slot_t s);
        slot_t r;
        r = (s == SLOT_LAST) ? '0 : s + 1'b1;
        return r;
    endfunction

    function automatic slot_t slot_prev(input slot_t s);
        slot_t r;
        r = (s == '0) ? SLOT_LAST : s - 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/deq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_if
// Request and response channels of the double-ended queue.
// ----------------------------------------------------------------------------
interface deq_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [deq_pkg::MODE_W-1:0]            mode;
    logic signed [deq_pkg::DATA_W-1:0]     push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface deq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [deq_pkg::DATA_W-1:0]     popped_value;
    logic                                  pop_valid;
    logic                                  push_dropped;
    logic [deq_pkg::CNT_W-1:0]             entry_count;
    logic                                  is_empty;
    logic signed [deq_pkg::DATA_W-1:0]     front_value;
    logic signed [deq_pkg::DATA_W-1:0]     back_value;
    logic                                  ends_valid;

    modport source (output valid, output popped_value, output pop_valid,
                    output push_dropped, output entry_count, output is_empty,
                    output front_value, output back_value, output ends_valid,
                    input ready);
    modport sink   (input valid, input popped_value, input pop_valid,
                    input push_dropped, input entry_count, input is_empty,
                    input front_value, input back_value, input ends_valid,
                    output ready);
endinterface
`default_nettype wire

>>> hdl/deq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hdl/deq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl
// Slot pointers, count and cached end values; drives the entry RAM and
// forms one result per beat.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire deq_pkg::mode_t    req_mode,
    input  wire deq_pkg::data_t    req_value,
    input  wire logic              out_free,
    output logic                   req_ready,
    output deq_pkg::ram_cmd_t      ram_cmd,
    input  wire deq_pkg::data_t    ram_rdata,
    output logic                   result_load,
    output deq_pkg::result_t       result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic              state_reg,      state_next;
    deq_pkg::slot_t    front_slot_reg, front_slot_next;
    deq_pkg::slot_t    back_slot_reg,  back_slot_next;
    deq_pkg::count_t   count_reg,      count_next;
    deq_pkg::data_t    front_val_reg,  front_val_next;
    deq_pkg::data_t    back_val_reg,   back_val_next;
    deq_pkg::data_t    popped_reg,     popped_next;
    logic              pend_front_reg, pend_front_next;

    logic              accept;
    logic              is_full;
    logic              is_empty_now;
    logic              head_pop_ok;
    logic              tail_pop_ok;
    logic              head_push_ok;
    logic              tail_push_ok;
    logic              is_push;
    logic              ends_ok;
    deq_pkg::data_t    front_out;
    deq_pkg::data_t    back_out;

    assign req_ready    = (state_reg == ST_IDLE) && out_free;
    assign accept       = req_valid && req_ready;
    assign is_full      = (count_reg == deq_pkg::COUNT_FULL);
    assign is_empty_now = (count_reg == '0);
    assign is_push      = (req_mode == deq_pkg::MODE_PUSH_FRONT) ||
                          (req_mode == deq_pkg::MODE_PUSH_BACK);
    assign head_push_ok = (req_mode == deq_pkg::MODE_PUSH_FRONT) && !is_full;
    assign tail_push_ok = (req_mode == deq_pkg::MODE_PUSH_BACK) && !is_full;
    assign head_pop_ok  = (req_mode == deq_pkg::MODE_POP_FRONT) && !is_empty_now;
    assign tail_pop_ok  = (req_mode == deq_pkg::MODE_POP_BACK) && !is_empty_now;

    always_comb
    begin
        state_next      = state_reg;
        front_slot_next = front_slot_reg;
        back_slot_next  = back_slot_reg;
        count_next      = count_reg;
        front_val_next  = front_val_reg;
        back_val_next   = back_val_reg;
        popped_next     = popped_reg;
        pend_front_next = pend_front_reg;
        ram_cmd.we      = 1'b0;
        ram_cmd.waddr   = back_slot_reg;
        ram_cmd.wdata   = req_value;
        ram_cmd.raddr   = deq_pkg::slot_next(front_slot_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (head_push_ok)
                    begin
                        front_slot_next = deq_pkg::slot_prev(front_slot_reg);
                        ram_cmd.we      = 1'b1;
                        ram_cmd.waddr   = deq_pkg::slot_prev(front_slot_reg);
                        count_next      = count_reg + 1'b1;
                        front_val_next  = req_value;
                        if (is_empty_now)
                        begin
                            back_val_next = req_value;
                        end
                    end
                    else if (tail_push_ok)
                    begin
                        back_slot_next = deq_pkg::slot_next(back_slot_reg);
                        ram_cmd.we     = 1'b1;
                        count_next     = count_reg + 1'b1;
                        back_val_next  = req_value;
                        if (is_empty_now)
                        begin
                            front_val_next = req_value;
                        end
                    end
                    else if (head_pop_ok)
                    begin
                        popped_next     = front_val_reg;
                        front_slot_next = deq_pkg::slot_next(front_slot_reg);
                        count_next      = count_reg - 1'b1;
                        pend_front_next = 1'b1;
                        state_next      = ST_READ;
                    end
                    else if (tail_pop_ok)
                    begin
                        popped_next     = back_val_reg;
                        back_slot_next  = deq_pkg::slot_prev(back_slot_reg);
                        ram_cmd.raddr   = deq_pkg::slot_prev(
                                              deq_pkg::slot_prev(back_slot_reg));
                        count_next      = count_reg - 1'b1;
                        pend_front_next = 1'b0;
                        state_next      = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (pend_front_reg)
                begin
                    front_val_next = ram_rdata;
                end
                else
                begin
                    back_val_next = ram_rdata;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result of a one-beat item, or of a pop once its new end arrives
    always_comb
    begin
        result_load = 1'b0;
        result      = '0;
        front_out   = front_val_next;
        back_out    = back_val_next;
        ends_ok     = (count_next != '0);

        if (state_reg == ST_READ)
        begin
            result_load        = 1'b1;
            result.popped_value = popped_reg;
            result.pop_valid   = 1'b1;
        end
        else if (accept && !head_pop_ok && !tail_pop_ok)
        begin
            result_load         = 1'b1;
            result.push_dropped = is_push && is_full;
        end

        result.entry_count = count_next;
        result.is_empty    = !ends_ok;
        result.ends_valid  = ends_ok;
        result.front_value = ends_ok ? front_out : '0;
        result.back_value  = ends_ok ? back_out : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            front_slot_reg <= '0;
            back_slot_reg  <= '0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            front_slot_reg <= front_slot_next;
            back_slot_reg  <= back_slot_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_val_reg  <= front_val_next;
        back_val_reg   <= back_val_next;
        popped_reg     <= popped_next;
        pend_front_reg <= pend_front_next;
    end

endmodule
`default_nettype wire

>>> hdl/double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue in a circular RAM of DEPTH words with one result per
// request beat.
// ----------------------------------------------------------------------------
//  port   dir   beat contents
//  req    in    mode, push_value
//  rsp    out   popped_value, pop_valid, push_dropped, entry_count,
//               is_empty, front_value, back_value, ends_valid
//
//  push, query, refused push and pop on empty: result formed with no RAM read
//  pop with data: held in ST_READ for the registered RAM read of the new end
//  the response register frees req for the next beat as a waiting result is taken
//  rsp stall holds req off only once a result is already waiting
//  reset clears pointers and count; RAM contents need no clearing
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    logic                 rsp_valid_reg;
    deq_pkg::result_t     rsp_data_reg;
    logic                 out_free;
    logic                 result_load;
    deq_pkg::result_t     result;
    deq_pkg::ram_cmd_t    ram_cmd;
    deq_pkg::data_t       ram_rdata;

    assign out_free = !rsp_valid_reg || rsp.ready;

    deq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_mode    (req.mode),
        .req_value   (req.push_value),
        .out_free    (out_free),
        .req_ready   (req.ready),
        .ram_cmd     (ram_cmd),
        .ram_rdata   (ram_rdata),
        .result_load (result_load),
        .result      (result)
    );

    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (deq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_cmd.we),
        .waddr (ram_cmd.waddr),
        .wdata (ram_cmd.wdata),
        .raddr (ram_cmd.raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.popped_value = rsp_data_reg.popped_value;
    assign rsp.pop_valid    = rsp_data_reg.pop_valid;
    assign rsp.push_dropped = rsp_data_reg.push_dropped;
    assign rsp.entry_count  = rsp_data_reg.entry_count;
    assign rsp.is_empty     = rsp_data_reg.is_empty;
    assign rsp.front_value  = rsp_data_reg.front_value;
    assign rsp.back_value   = rsp_data_reg.back_value;
    assign rsp.ends_valid   = rsp_data_reg.ends_valid;

    // a non-pop beat has its result on the next cycle
    a_nonpop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.mode != deq_pkg::MODE_POP_FRONT &&
         req.mode != deq_pkg::MODE_POP_BACK) |=> rsp.valid)
        else $error("non-pop beat produced no result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.entry_count <= deq_pkg::COUNT_FULL))
        else $error("entry count beyond depth");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.pop_valid && rsp.push_dropped))
        else $error("pop and dropped push flagged together");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.is_empty) |->
            (!rsp.ends_valid && rsp.entry_count == '0))
        else $error("empty result with live ends");

    // no result may be overwritten while it waits
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !result_load)
        else $error("result loaded over a waiting result");

endmodule
`default_nettype wire

>>> dv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double-ended queue. A directed table covers
// the empty deque, the value extremes, both ends, ignored push values and the
// spare mode codes. Random traffic follows: a stretch with no idling, a long
// response stall, a pause until every response is back, a push-heavy climb,
// a drain back to empty, and a mixed walk. Every response beat is compared
// field by field against a fixed row's expected result, or a shadow deque.
// ----------------------------------------------------------------------------
module tb;

    localparam deq_pkg::mode_t MODE_QUERY   = 3'd4;
    localparam deq_pkg::mode_t MODE_SPARE_A = 3'd5;
    localparam deq_pkg::mode_t MODE_SPARE_B = 3'd6;
    localparam deq_pkg::mode_t MODE_SPARE_C = 3'd7;

    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 40;

    localparam deq_pkg::result_t EMPTY_RESULT =
        {32'h0, 1'b0, 1'b0, 11'd0, 1'b1, 32'h0, 32'h0, 1'b0};

    typedef struct {
        deq_pkg::mode_t   mode;
        deq_pkg::data_t   value;
        bit               fixed;
        deq_pkg::result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    deq_pkg::data_t   shadow_store [deq_pkg::DEPTH];
    int               shadow_head;
    int               shadow_held;
    deq_pkg::result_t pending_results [$];
    stim_row_t        plan [$];

    bit               quiet;
    bit               hold_request;
    bit               cur_fixed;
    deq_pkg::result_t cur_want;

    int errors;
    int stuck_cycles;
    int n_beats;
    int n_push_ok;
    int n_drop;
    int n_pop_ok;
    int n_pop_empty;
    int n_checked;
    int max_held;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic deq_pkg::result_t apply_deque_op(input deq_pkg::mode_t m,
                                                        input deq_pkg::data_t v);
        deq_pkg::result_t r;
        int               tail;
        r = '0;
        if (m == deq_pkg::MODE_PUSH_FRONT || m == deq_pkg::MODE_PUSH_BACK)
        begin
            if (shadow_held == deq_pkg::DEPTH)
                r.push_dropped = 1'b1;
            else if (m == deq_pkg::MODE_PUSH_FRONT)
            begin
                shadow_head = (shadow_head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                shadow_store[shadow_head] = v;
                shadow_held++;
            end
            else
            begin
                shadow_store[(shadow_head + shadow_held) % deq_pkg::DEPTH] = v;
                shadow_held++;
            end
        end
        else if ((m == deq_pkg::MODE_POP_FRONT || m == deq_pkg::MODE_POP_BACK) &&
                 shadow_held != 0)
        begin
            if (m == deq_pkg::MODE_POP_FRONT)
            begin
                r.popped_value = shadow_store[shadow_head];
                shadow_head = (shadow_head + 1) % deq_pkg::DEPTH;
            end
            else
                r.popped_value =
                    shadow_store[(shadow_head + shadow_held - 1) % deq_pkg::DEPTH];
            r.pop_valid = 1'b1;
            shadow_held--;
        end
        r.entry_count = deq_pkg::count_t'(shadow_held);
        r.is_empty    = (shadow_held == 0);
        if (shadow_held != 0)
        begin
            tail          = (shadow_head + shadow_held - 1) % deq_pkg::DEPTH;
            r.front_value = shadow_store[shadow_head];
            r.back_value  = shadow_store[tail];
            r.ends_valid  = 1'b1;
        end
        return r;
    endfunction

    function automatic deq_pkg::mode_t pick_mode(input int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct)
            return r[0] ? deq_pkg::MODE_PUSH_BACK : deq_pkg::MODE_PUSH_FRONT;
        if (r < 90)
            return r[0] ? deq_pkg::MODE_POP_BACK : deq_pkg::MODE_POP_FRONT;
        return deq_pkg::mode_t'($urandom_range(7));
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    // response checking and request scoring at the rising edge
    always @(posedge clk)
    begin : monitor
        deq_pkg::result_t want;
        deq_pkg::result_t got;
        if (req_ch.valid && req_ch.ready)
        begin
            want = apply_deque_op(req_ch.mode, req_ch.push_value);
            if (cur_fixed)
                want = cur_want;
            pending_results = {pending_results, want};
            n_beats++;
            n_push_ok   += int'((req_ch.mode inside {deq_pkg::MODE_PUSH_FRONT,
                                                     deq_pkg::MODE_PUSH_BACK})
                                && !want.push_dropped);
            n_drop      += int'(want.push_dropped);
            n_pop_ok    += int'(want.pop_valid);
            n_pop_empty += int'((req_ch.mode inside {deq_pkg::MODE_POP_FRONT,
                                                     deq_pkg::MODE_POP_BACK})
                                && !want.pop_valid);
            if (shadow_held > max_held)
                max_held = shadow_held;
        end
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            got = {rsp_ch.popped_value, rsp_ch.pop_valid, rsp_ch.push_dropped,
                   rsp_ch.entry_count, rsp_ch.is_empty, rsp_ch.front_value,
                   rsp_ch.back_value, rsp_ch.ends_valid};
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: response beat with none expected, actual %h", $time, got);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("popped_value", want.popped_value, got.popped_value);
                check_field("pop_valid", 32'(want.pop_valid), 32'(got.pop_valid));
                check_field("push_dropped", 32'(want.push_dropped),
                            32'(got.push_dropped));
                check_field("entry_count", 32'(want.entry_count),
                            32'(got.entry_count));
                check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                check_field("front_value", want.front_value, got.front_value);
                check_field("back_value", want.back_value, got.back_value);
                check_field("ends_valid", 32'(want.ends_valid), 32'(got.ends_valid));
                n_checked++;
            end
        end
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
    end

    initial
    begin : watchdog
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // response side: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                rsp_ch.ready <= quiet || ($urandom_range(99) >= 25);
        end
    end

    // entered and left at a falling edge
    task automatic send_beat(input deq_pkg::mode_t m, input deq_pkg::data_t v,
                             input bit fixed, input deq_pkg::result_t want);
        while (!quiet && $urandom_range(99) < 25)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= m;
        req_ch.push_value <= v;
        cur_fixed = fixed;
        cur_want  = want;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_random(input int beats, input int push_pct);
        repeat (beats)
            send_beat(pick_mode(push_pct), deq_pkg::data_t'($urandom), 1'b0, '0);
    endtask

    task automatic add_row(input deq_pkg::mode_t m, input deq_pkg::data_t v,
                           input bit fixed, input deq_pkg::result_t want);
        stim_row_t row;
        row.mode  = m;
        row.value = v;
        row.fixed = fixed;
        row.want  = want;
        plan = {plan, row};
    endtask

    // stop offering and wait for every outstanding response
    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : sender
        clk               = 1'b0;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = MODE_QUERY;
        req_ch.push_value = '0;
        quiet             = 1'b0;
        hold_request      = 1'b0;
        cur_fixed         = 1'b0;
        cur_want          = '0;
        shadow_head       = 0;
        shadow_held       = 0;

        add_row(MODE_QUERY, 32'h0, 1'b1, EMPTY_RESULT);
        add_row(deq_pkg::MODE_POP_FRONT, 32'h0, 1'b1, EMPTY_RESULT);
        add_row(deq_pkg::MODE_POP_BACK, 32'hFFFF_FFFF, 1'b1, EMPTY_RESULT);
        add_row(deq_pkg::MODE_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1,
                {32'h0, 1'b0, 1'b0, 11'd1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1});
        add_row(deq_pkg::MODE_PUSH_BACK, 32'h8000_0000, 1'b1,
                {32'h0, 1'b0, 1'b0, 11'd2, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1});
        add_row(deq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1,
                {32'h0, 1'b0, 1'b0, 11'd3, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1});
        add_row(deq_pkg::MODE_PUSH_BACK, 32'h0, 1'b1,
                {32'h0, 1'b0, 1'b0, 11'd4, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b1});
        add_row(MODE_QUERY, 32'hAAAA_AAAA, 1'b1,
                {32'h0, 1'b0, 1'b0, 11'd4, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b1});
        add_row(MODE_SPARE_A, 32'h5555_5555, 1'b1,
                {32'h0, 1'b0, 1'b0, 11'd4, 1'b0, 32'hFFFF_FFFF, 32'h0, 1'b1});
        add_row(MODE_SPARE_B, 32'h1234_5678, 1'b0, '0);
        add_row(MODE_SPARE_C, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(deq_pkg::MODE_POP_FRONT, 32'h0, 1'b1,
                {32'hFFFF_FFFF, 1'b1, 1'b0, 11'd3, 1'b0, 32'h7FFF_FFFF, 32'h0, 1'b1});
        add_row(deq_pkg::MODE_POP_BACK, 32'h0, 1'b1,
                {32'h0, 1'b1, 1'b0, 11'd2, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1});
        add_row(deq_pkg::MODE_POP_BACK, 32'h0, 1'b1,
                {32'h8000_0000, 1'b1, 1'b0, 11'd1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 1'b1});
        add_row(deq_pkg::MODE_POP_FRONT, 32'h0, 1'b1,
                {32'h7FFF_FFFF, 1'b1, 1'b0, 11'd0, 1'b1, 32'h0, 32'h0, 1'b0});
        add_row(deq_pkg::MODE_POP_BACK, 32'h0, 1'b1, EMPTY_RESULT);
        add_row(deq_pkg::MODE_PUSH_BACK, 32'h0000_0001, 1'b0, '0);
        add_row(deq_pkg::MODE_PUSH_BACK, 32'h0000_0002, 1'b0, '0);
        add_row(deq_pkg::MODE_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, '0);
        add_row(deq_pkg::MODE_POP_BACK, 32'h0, 1'b0, '0);
        add_row(deq_pkg::MODE_POP_FRONT, 32'h0, 1'b0, '0);
        add_row(deq_pkg::MODE_POP_FRONT, 32'h0, 1'b0, '0);
        add_row(deq_pkg::MODE_PUSH_FRONT, 32'h1234_5678, 1'b0, '0);
        add_row(deq_pkg::MODE_POP_BACK, 32'h0, 1'b0, '0);

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
            send_beat(plan[i].mode, plan[i].value, plan[i].fixed, plan[i].want);

        // no idling on either side
        quiet = 1'b1;
        send_random(150, 50);
        quiet = 1'b0;

        // long response stall while requests keep coming
        hold_request = 1'b1;
        send_random(40, 60);

        // pause until every response is back
        wait_drain();

        // push-heavy climb, then drain to empty
        send_random(100, 80);
        while (shadow_held > 0)
            send_beat(pick_mode(0), deq_pkg::data_t'($urandom), 1'b0, '0);

        send_random(100, 55);

        wait_drain();
        repeat (8) @(negedge clk);

        $display("%0d request beats, %0d responses checked, peak depth %0d of %0d",
                 n_beats, n_checked, max_held, deq_pkg::DEPTH);
        $display("pushes %0d, refused %0d, pops %0d, pops on empty %0d",
                 n_push_ok, n_drop, n_pop_ok, n_pop_empty);
        if (errors == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d mismatches, %0d responses missing", errors,
                     pending_results.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
